// ----- hdl/hcbc_pkg.sv -----
// Shared types and constants for the hourly chime buzzer controller.
package hcbc_pkg;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_CHECK      = 2'd1,
    CMD_CANCEL_REQ = 2'd2,
    CMD_CANCEL_NOW = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_SHORT_BEEP = 1'b0,
    REG_LONG_BEEP  = 1'b1
  } reg_idx_e;

  localparam int unsigned TickW   = 6;
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;

  localparam logic [TickW-1:0]   ShortBeepRst = 6'd8;
  localparam logic [TickW-1:0]   LongBeepRst  = 6'd50;
  localparam logic [SecondW-1:0] SecondNone   = 6'h3F;
  localparam logic [YearW-1:0]   YearFirst    = 12'd2000;
  localparam logic [YearW-1:0]   YearLast     = 12'd2099;
  localparam logic [MonthW-1:0]  MonthFirst   = 4'd1;
  localparam logic [MonthW-1:0]  MonthLast    = 4'd12;
  localparam logic [MinuteW-1:0] MinuteLast   = 6'd59;
  localparam logic [SecondW-1:0] SecondPre    = 6'd55;
  localparam logic [SecondW-1:0] SecondLast   = 6'd59;
  localparam logic [HourW:0]     HoursPerDay  = 6'd24;

  typedef struct packed {
    logic [TickW-1:0] short_ticks;
    logic [TickW-1:0] long_ticks;
  } cfg_t;

endpackage

// ----- hdl/hcbc_if.sv -----
// Valid/ready channel interfaces for command items and buzzer results.
interface hcbc_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       cmd;
  logic [hcbc_pkg::YearW-1:0]       year;
  logic [hcbc_pkg::MonthW-1:0]      month;
  logic [hcbc_pkg::HourW-1:0]       hour;
  logic [hcbc_pkg::MinuteW-1:0]     minute;
  logic [hcbc_pkg::SecondW-1:0]     second;

  modport source (output valid, cmd, year, month, hour, minute, second, input ready);
  modport sink   (input valid, cmd, year, month, hour, minute, second, output ready);
endinterface

interface hcbc_out_if;
  logic valid;
  logic ready;
  logic buzzer_drive;
  logic chime_suppressed;

  modport source (output valid, buzzer_drive, chime_suppressed, input ready);
  modport sink   (input valid, buzzer_drive, chime_suppressed, output ready);
endinterface

// ----- hdl/hcbc_apb_regs.sv -----
// APB register file holding the two beep durations.
module hcbc_apb_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hcbc_pkg::PaddrW-1:0]    paddr,
  input  logic [hcbc_pkg::PdataW-1:0]    pwdata,
  output logic [hcbc_pkg::PdataW-1:0]    prdata,
  output logic                           pready,
  output hcbc_pkg::cfg_t                 cfg_o
);

  hcbc_pkg::cfg_t   cfg_q, cfg_d;
  logic             wr_en;
  logic             idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  // Low address bits are ignored: the register index is the word address.
  assign idx    = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        hcbc_pkg::REG_SHORT_BEEP: cfg_d.short_ticks = pwdata[hcbc_pkg::TickW-1:0];
        hcbc_pkg::REG_LONG_BEEP:  cfg_d.long_ticks  = pwdata[hcbc_pkg::TickW-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      hcbc_pkg::REG_SHORT_BEEP:
        prdata = {{(hcbc_pkg::PdataW-hcbc_pkg::TickW){1'b0}}, cfg_q.short_ticks};
      hcbc_pkg::REG_LONG_BEEP:
        prdata = {{(hcbc_pkg::PdataW-hcbc_pkg::TickW){1'b0}}, cfg_q.long_ticks};
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_ticks <= hcbc_pkg::ShortBeepRst;
      cfg_q.long_ticks  <= hcbc_pkg::LongBeepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/hcbc_core.sv -----
// Buzzer and suppression state update with registered result stage.
module hcbc_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hcbc_pkg::cfg_t cfg_i,
  hcbc_in_if.sink        in_ch,
  hcbc_out_if.source     out_ch
);

  logic [hcbc_pkg::TickW-1:0]   rem_q, rem_d;
  logic                         snd_q, snd_d;
  logic [hcbc_pkg::SecondW-1:0] last_sec_q, last_sec_d;
  logic                         supp_q, supp_d;
  logic [hcbc_pkg::HourW-1:0]   supp_hour_q, supp_hour_d;
  logic                         out_valid_q;
  logic                         buzz_q, supp_out_q;

  logic                         accept;
  logic                         date_ok;
  logic                         pre_hour;
  logic                         top_hour;
  logic                         blocked;
  logic [hcbc_pkg::TickW-1:0]   dur;
  logic [hcbc_pkg::HourW:0]     hour_inc;
  logic [hcbc_pkg::HourW-1:0]   next_hour;
  hcbc_pkg::cmd_e               cmd;

  // Take a new transaction whenever the result slot is free or draining.
  assign in_ch.ready = ~out_valid_q | out_ch.ready;
  assign accept      = in_ch.valid & in_ch.ready;
  assign cmd         = hcbc_pkg::cmd_e'(in_ch.cmd);

  assign date_ok  = (in_ch.year >= hcbc_pkg::YearFirst) && (in_ch.year <= hcbc_pkg::YearLast)
                 && (in_ch.month >= hcbc_pkg::MonthFirst)
                 && (in_ch.month <= hcbc_pkg::MonthLast);
  assign pre_hour = (in_ch.minute == hcbc_pkg::MinuteLast)
                 && (in_ch.second >= hcbc_pkg::SecondPre)
                 && (in_ch.second <= hcbc_pkg::SecondLast);
  assign top_hour = (in_ch.minute == '0) && (in_ch.second == '0);
  assign dur      = pre_hour ? cfg_i.short_ticks : (top_hour ? cfg_i.long_ticks : '0);

  // Wrap the following hour; the sum stays below twice a day's hours.
  assign hour_inc  = {1'b0, in_ch.hour} + 1'b1;
  assign next_hour = (hour_inc >= hcbc_pkg::HoursPerDay)
                   ? hcbc_pkg::HourW'(hour_inc - hcbc_pkg::HoursPerDay)
                   : hour_inc[hcbc_pkg::HourW-1:0];

  always_comb begin
    rem_d       = rem_q;
    snd_d       = snd_q;
    last_sec_d  = last_sec_q;
    supp_d      = supp_q;
    supp_hour_d = supp_hour_q;
    blocked     = 1'b0;
    case (cmd)
      hcbc_pkg::CMD_TICK: begin
        if (snd_q) begin
          if (rem_q == '0) begin
            snd_d = 1'b0;
          end else begin
            rem_d = rem_q - 1'b1;
            if (rem_q == hcbc_pkg::TickW'(1)) snd_d = 1'b0;
          end
        end
      end
      hcbc_pkg::CMD_CHECK: begin
        if (in_ch.second != last_sec_q) begin
          last_sec_d = in_ch.second;
          if (supp_q) begin
            if ((in_ch.hour == supp_hour_q) && (in_ch.second != '0)) begin
              supp_d      = 1'b0;
              supp_hour_d = '0;
            end else begin
              blocked = 1'b1;
            end
          end
          if (!blocked && date_ok && (dur != '0)) begin
            snd_d = 1'b1;
            rem_d = dur;
          end
        end
      end
      hcbc_pkg::CMD_CANCEL_REQ: begin
        supp_hour_d = (in_ch.minute == hcbc_pkg::MinuteLast) ? next_hour : in_ch.hour;
        supp_d      = 1'b1;
        snd_d       = 1'b0;
        rem_d       = '0;
      end
      hcbc_pkg::CMD_CANCEL_NOW: begin
        snd_d = 1'b0;
        rem_d = '0;
      end
      default: begin
        snd_d = snd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      snd_q       <= 1'b0;
      last_sec_q  <= hcbc_pkg::SecondNone;
      supp_q      <= 1'b0;
      supp_hour_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        rem_q       <= rem_d;
        snd_q       <= snd_d;
        last_sec_q  <= last_sec_d;
        supp_q      <= supp_d;
        supp_hour_q <= supp_hour_d;
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buzz_q     <= snd_d;
      supp_out_q <= supp_d;
    end
  end

  assign out_ch.valid            = out_valid_q;
  assign out_ch.buzzer_drive     = buzz_q;
  assign out_ch.chime_suppressed = supp_out_q;

endmodule

// ----- hdl/hourly_chime_buzzer_controller.sv -----
// A result appears in the cycle after its input transaction is accepted; one
// transaction per cycle while out_o is ready. The single result register sets the
// rate, and a new item is taken in the same cycle that the waiting result is taken.
// Reset (async, active low): buzzer silent, no suppression, last second invalid,
// beep durations 8 and 50 ticks, result register empty.
module hourly_chime_buzzer_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  hcbc_in_if.sink                     in_i,
  hcbc_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hcbc_pkg::PaddrW-1:0] paddr,
  input  logic [hcbc_pkg::PdataW-1:0] pwdata,
  output logic [hcbc_pkg::PdataW-1:0] prdata,
  output logic                        pready
);

  hcbc_pkg::cfg_t cfg;

  hcbc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hcbc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_ch  (in_i),
    .out_ch (out_o)
  );

endmodule

// ----- tb/hourly_chime_buzzer_controller_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench: random and directed clock events against a buzzer predictor.
module hourly_chime_buzzer_controller_tb;

  typedef struct packed {
    hcbc_pkg::cmd_e                 cmd;
    logic [hcbc_pkg::YearW-1:0]     year;
    logic [hcbc_pkg::MonthW-1:0]    month;
    logic [hcbc_pkg::HourW-1:0]     hour;
    logic [hcbc_pkg::MinuteW-1:0]   minute;
    logic [hcbc_pkg::SecondW-1:0]   second;
  } clock_event_t;

  typedef struct packed {
    logic buzzer_drive;
    logic chime_suppressed;
  } buzzer_state_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [hcbc_pkg::PaddrW-1:0] paddr;
  logic [hcbc_pkg::PdataW-1:0] pwdata;
  logic [hcbc_pkg::PdataW-1:0] prdata;
  logic                        pready;

  hcbc_in_if  in_if ();
  hcbc_out_if out_if ();

  hourly_chime_buzzer_controller dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  clock_event_t  event_q[$];
  buzzer_state_t buzzer_exp_q[$];
  bit            in_busy;
  int unsigned   err_count;
  int unsigned   queued;
  int unsigned   send_idle_pct;
  int unsigned   stall_pct;
  int unsigned   pressure_req;
  int unsigned   pressure_seen;
  int unsigned   hold_left;

  // predictor copy of the block's registers and state
  logic [hcbc_pkg::TickW-1:0]   short_cfg;
  logic [hcbc_pkg::TickW-1:0]   long_cfg;
  logic [hcbc_pkg::TickW-1:0]   ticks_left;
  logic                         buzzing;
  logic                         cancel_armed;
  logic [hcbc_pkg::HourW-1:0]   cancel_hour;
  logic [hcbc_pkg::SecondW-1:0] seen_second;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic buzzer_state_t predict_buzzer(input clock_event_t ev);
    buzzer_state_t              r;
    logic                       blocked;
    logic                       fire;
    logic [hcbc_pkg::TickW-1:0] dur;
    blocked = 1'b0;
    fire    = 1'b0;
    dur     = '0;
    case (ev.cmd)
      hcbc_pkg::CMD_TICK: begin
        if (buzzing) begin
          if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
          if (ticks_left == '0) buzzing = 1'b0;
        end
      end
      hcbc_pkg::CMD_CHECK: begin
        if (ev.second != seen_second) begin
          seen_second = ev.second;
          // release only inside the target hour and past its first second
          if (cancel_armed) begin
            if (ev.hour == cancel_hour && ev.second != '0) begin
              cancel_armed = 1'b0;
              cancel_hour  = '0;
            end else begin
              blocked = 1'b1;
            end
          end
          if (!blocked) begin
            if (ev.minute == hcbc_pkg::MinuteLast && ev.second >= hcbc_pkg::SecondPre &&
                ev.second <= hcbc_pkg::SecondLast) begin
              fire = 1'b1;
              dur  = short_cfg;
            end else if (ev.minute == '0 && ev.second == '0) begin
              fire = 1'b1;
              dur  = long_cfg;
            end
          end
          // a zero duration or a date out of range leaves the buzzer as it is
          if (fire && dur != '0 &&
              ev.year >= hcbc_pkg::YearFirst && ev.year <= hcbc_pkg::YearLast &&
              ev.month >= hcbc_pkg::MonthFirst && ev.month <= hcbc_pkg::MonthLast) begin
            buzzing    = 1'b1;
            ticks_left = dur;
          end
        end
      end
      hcbc_pkg::CMD_CANCEL_REQ: begin
        cancel_hour  = (ev.minute == hcbc_pkg::MinuteLast) ?
                       hcbc_pkg::HourW'((int'(ev.hour) + 1) % int'(hcbc_pkg::HoursPerDay)) :
                       ev.hour;
        cancel_armed = 1'b1;
        buzzing      = 1'b0;
        ticks_left   = '0;
      end
      hcbc_pkg::CMD_CANCEL_NOW: begin
        buzzing    = 1'b0;
        ticks_left = '0;
      end
    endcase
    r.buzzer_drive     = buzzing;
    r.chime_suppressed = cancel_armed;
    return r;
  endfunction

  task automatic flag_error(input string what, input int want, input int got);
    if (err_count < 10)
      $display("mismatch %0d at %0t: %s expected %0d got %0d",
               err_count + 1, $time, what, want, got);
    err_count++;
  endtask

  // drive the oldest pending event, hold it until its transaction completes
  always @(negedge clk_i) begin
    if (!in_busy) begin
      if (event_q.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
        in_if.cmd    <= event_q[0].cmd;
        in_if.year   <= event_q[0].year;
        in_if.month  <= event_q[0].month;
        in_if.hour   <= event_q[0].hour;
        in_if.minute <= event_q[0].minute;
        in_if.second <= event_q[0].second;
        in_if.valid  <= 1'b1;
        in_busy = 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (pressure_req != pressure_seen) begin
      pressure_seen <= pressure_req;
      hold_left     <= 64;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk_i)
    out_if.ready <= (hold_left == 0) && ($urandom_range(1, 100) > stall_pct);

  always @(posedge clk_i) begin
    buzzer_state_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (buzzer_exp_q.size() == 0) begin
          flag_error("result with nothing outstanding", 0, 1);
        end else begin
          want = buzzer_exp_q.pop_front();
          if (out_if.buzzer_drive !== want.buzzer_drive)
            flag_error("buzzer_drive", want.buzzer_drive, out_if.buzzer_drive);
          if (out_if.chime_suppressed !== want.chime_suppressed)
            flag_error("chime_suppressed", want.chime_suppressed, out_if.chime_suppressed);
        end
      end
      if (in_if.valid && in_if.ready) begin
        buzzer_exp_q.push_back(predict_buzzer(event_q.pop_front()));
        in_busy = 1'b0;
      end
    end
  end

  function automatic void queue_event(input hcbc_pkg::cmd_e cmd, input int yr, input int mo,
                                      input int hr, input int mi, input int sec);
    clock_event_t ev;
    ev.cmd    = cmd;
    ev.year   = hcbc_pkg::YearW'(yr);
    ev.month  = hcbc_pkg::MonthW'(mo);
    ev.hour   = hcbc_pkg::HourW'(hr);
    ev.minute = hcbc_pkg::MinuteW'(mi);
    ev.second = hcbc_pkg::SecondW'(sec);
    event_q.push_back(ev);
    queued++;
  endfunction

  function automatic void queue_noise(input int n);
    for (int i = 0; i < n; i++)
      queue_event(hcbc_pkg::cmd_e'($urandom_range(0, 3)), $urandom_range(0, 4095),
                  $urandom_range(0, 15), $urandom_range(0, 31),
                  $urandom_range(0, 63), $urandom_range(0, 63));
  endfunction

  function automatic void queue_ticks(input int n);
    for (int i = 0; i < n; i++)
      queue_event(hcbc_pkg::CMD_TICK, $urandom_range(0, 4095), $urandom_range(0, 15),
                  $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
  endfunction

  // countdown into the top of an hour, with cancels, repeats and tick bursts
  function automatic void queue_hour_turn();
    int yr;
    int mo;
    int hr;
    int nxt;
    yr  = ($urandom_range(0, 7) == 0) ? $urandom_range(1990, 2110) : $urandom_range(2000, 2099);
    mo  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    hr  = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
    nxt = ($urandom_range(0, 7) == 0) ? hr : (hr + 1) % 24;
    if ($urandom_range(0, 3) == 0)
      queue_event(hcbc_pkg::CMD_CANCEL_REQ, yr, mo, hr,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : 59,
                  $urandom_range(0, 63));
    for (int s = $urandom_range(50, 56); s <= 59; s++) begin
      queue_event(hcbc_pkg::CMD_CHECK, yr, mo, hr, 59, s);
      if ($urandom_range(0, 4) == 0) queue_event(hcbc_pkg::CMD_CHECK, yr, mo, hr, 59, s);
      queue_ticks($urandom_range(0, 3));
      if ($urandom_range(0, 24) == 0) queue_event(hcbc_pkg::CMD_CANCEL_NOW, yr, mo, hr, 59, s);
    end
    queue_event(hcbc_pkg::CMD_CHECK, yr, mo, nxt, 0, 0);
    queue_ticks($urandom_range(0, 10));
    queue_event(hcbc_pkg::CMD_CHECK, yr, mo, nxt, 0, 1);
    queue_ticks(($urandom_range(0, 4) == 0) ? $urandom_range(20, 63) : $urandom_range(0, 8));
  endfunction

  task automatic wait_drained();
    while (event_q.size() != 0 || in_busy || buzzer_exp_q.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic apb_write(input hcbc_pkg::reg_idx_e idx,
                           input logic [hcbc_pkg::PdataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= hcbc_pkg::PaddrW'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == hcbc_pkg::REG_SHORT_BEEP) short_cfg = data[hcbc_pkg::TickW-1:0];
    else long_cfg = data[hcbc_pkg::TickW-1:0];
  endtask

  task automatic run_phase(input logic [hcbc_pkg::TickW-1:0] s_ticks,
                           input logic [hcbc_pkg::TickW-1:0] l_ticks,
                           input int unsigned idle_pct, input int unsigned hold_pct,
                           input bit squeeze);
    int unsigned first;
    wait_drained();
    apb_write(hcbc_pkg::REG_SHORT_BEEP, {26'($urandom()), s_ticks});
    apb_write(hcbc_pkg::REG_LONG_BEEP, {26'($urandom()), l_ticks});
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    first         = queued;
    while (queued - first < 65) begin
      if ($urandom_range(0, 3) == 0) queue_noise($urandom_range(1, 6));
      else queue_hour_turn();
    end
    // starve the output so the result register fills and input backs up
    if (squeeze) pressure_req++;
  endtask

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_if.valid   = 1'b0;
    in_if.cmd     = hcbc_pkg::CMD_TICK;
    in_if.year    = '0;
    in_if.month   = '0;
    in_if.hour    = '0;
    in_if.minute  = '0;
    in_if.second  = '0;
    out_if.ready  = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    short_cfg     = hcbc_pkg::ShortBeepRst;
    long_cfg      = hcbc_pkg::LongBeepRst;
    ticks_left    = '0;
    buzzing       = 1'b0;
    cancel_armed  = 1'b0;
    cancel_hour   = '0;
    seen_second   = hcbc_pkg::SecondNone;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed events under the reset durations
    queue_event(hcbc_pkg::CMD_CHECK, 2000, 1, 3, 59, 63);
    queue_event(hcbc_pkg::CMD_TICK, 2000, 1, 3, 59, 0);
    queue_event(hcbc_pkg::CMD_CHECK, 2000, 1, 3, 59, 55);
    queue_event(hcbc_pkg::CMD_CHECK, 2000, 1, 3, 59, 55);
    queue_ticks(9);
    queue_event(hcbc_pkg::CMD_CHECK, 2099, 12, 3, 59, 59);
    queue_event(hcbc_pkg::CMD_CANCEL_NOW, 2099, 12, 3, 59, 59);
    queue_event(hcbc_pkg::CMD_CHECK, 2050, 0, 4, 59, 56);
    queue_event(hcbc_pkg::CMD_CHECK, 2050, 13, 4, 59, 57);
    queue_event(hcbc_pkg::CMD_CHECK, 2100, 5, 4, 59, 58);
    queue_event(hcbc_pkg::CMD_CHECK, 1999, 6, 4, 0, 0);
    queue_event(hcbc_pkg::CMD_CHECK, 2050, 6, 23, 59, 54);
    queue_event(hcbc_pkg::CMD_CANCEL_REQ, 2050, 6, 23, 59, 30);
    queue_event(hcbc_pkg::CMD_CHECK, 2050, 6, 0, 0, 0);
    queue_event(hcbc_pkg::CMD_CHECK, 2050, 6, 0, 0, 1);
    queue_event(hcbc_pkg::CMD_CANCEL_REQ, 2050, 6, 31, 10, 5);
    queue_event(hcbc_pkg::CMD_CANCEL_REQ, 2050, 6, 31, 59, 5);
    queue_event(hcbc_pkg::CMD_CHECK, 2050, 6, 8, 0, 0);
    queue_event(hcbc_pkg::CMD_CHECK, 2050, 6, 8, 0, 2);
    queue_event(hcbc_pkg::CMD_CHECK, 4095, 15, 31, 63, 63);
    queue_event(hcbc_pkg::CMD_CHECK, 2000, 1, 5, 0, 0);
    queue_event(hcbc_pkg::CMD_TICK, 2000, 1, 5, 0, 0);
    queue_event(hcbc_pkg::CMD_CANCEL_NOW, 2000, 1, 5, 0, 0);

    run_phase(6'd1, 6'd63, 0, 0, 1'b0);
    run_phase(6'd63, 6'd1, 86, 0, 1'b0);
    run_phase(6'd0, 6'd5, 0, 86, 1'b0);
    run_phase(6'd7, 6'd0, 22, 22, 1'b0);
    run_phase(hcbc_pkg::TickW'($urandom_range(1, 63)), hcbc_pkg::TickW'($urandom_range(1, 63)),
              0, 0, 1'b1);

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/hcbc_pkg.sv
hdl/hcbc_if.sv
hdl/hcbc_apb_regs.sv
hdl/hcbc_core.sv
hdl/hourly_chime_buzzer_controller.sv
tb/hourly_chime_buzzer_controller_tb.sv
